[design/cstm_pkg.sv]
// Shared types, widths and codes for the CAN signal check and timeout monitor.
`timescale 1ns / 1ps

package cstm_pkg;

    // Field widths.
    localparam int ID_W    = 29;
    localparam int DLC_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int VAL_W   = 16;
    localparam int TO_W    = 16;
    localparam int ST_W    = 3;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;
    localparam int NUM_SIG = 3;

    // Age counter width; the timeout compare runs at the wider of age and limit.
    localparam int AGE_BITS = 16;
    localparam int CMP_W    = (AGE_BITS > TO_W) ? AGE_BITS : TO_W;

    typedef logic [ID_W-1:0]     t_id;
    typedef logic [DLC_W-1:0]    t_dlc;
    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [VAL_W-1:0]    t_value;
    typedef logic [TO_W-1:0]     t_timeout;
    typedef logic [ST_W-1:0]     t_status;
    typedef logic [IDX_W-1:0]    t_reg_idx;
    typedef logic [DATA_W-1:0]   t_cfg_data;
    typedef logic [AGE_BITS-1:0] t_age;
    typedef logic [CMP_W-1:0]    t_cmp;

    localparam t_age AGE_MAX = '1;

    // Result status codes.
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_DLC         = 3'd1;
    localparam t_status ST_RANGE       = 3'd2;
    localparam t_status ST_HEARTBEAT   = 3'd3;
    localparam t_status ST_UNMONITORED = 3'd4;
    localparam t_status ST_TICK        = 3'd5;

    // Configuration register indexes.
    localparam t_reg_idx REG_ENGINE_ID     = 3'd0;
    localparam t_reg_idx REG_TEMP_ID       = 3'd1;
    localparam t_reg_idx REG_HEARTBEAT_ID  = 3'd2;
    localparam t_reg_idx REG_ENGINE_TO     = 3'd3;
    localparam t_reg_idx REG_TEMP_TO       = 3'd4;
    localparam t_reg_idx REG_HEARTBEAT_TO  = 3'd5;

    // Signal slots.
    localparam int SLOT_ENGINE    = 0;
    localparam int SLOT_TEMP      = 1;
    localparam int SLOT_HEARTBEAT = 2;

    // Reset values of the configuration registers.
    localparam t_id      RST_ENGINE_ID    = 29'd256;
    localparam t_id      RST_TEMP_ID      = 29'd257;
    localparam t_id      RST_HEARTBEAT_ID = 29'd258;
    localparam t_timeout RST_ENGINE_TO    = 16'd500;
    localparam t_timeout RST_TEMP_TO      = 16'd1000;
    localparam t_timeout RST_HEARTBEAT_TO = 16'd1000;

    // Payload check limits.
    localparam t_dlc   ENGINE_DLC     = 4'd2;
    localparam t_dlc   TEMP_DLC       = 4'd1;
    localparam t_dlc   HEARTBEAT_DLC  = 4'd1;
    localparam t_value RPM_MIN        = 16'd500;
    localparam t_value RPM_MAX        = 16'd4000;
    localparam t_byte  TEMP_MAX       = 8'd150;
    localparam t_byte  HEARTBEAT_BYTE = 8'hAA;

    // Frame classification handed from the checker to the top level.
    typedef struct packed {
        t_status            status;
        t_value             value;
        logic [NUM_SIG-1:0] hit;
    } t_check;

endpackage

[design/cstm_if.sv]
// Channel interfaces: frame/tick input, result output and configuration writes.
`timescale 1ns / 1ps

interface cstm_in_if import cstm_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  action;
    t_id   frame_id;
    t_dlc  frame_dlc;
    t_byte data_byte0;
    t_byte data_byte1;

    modport source (output valid, action, frame_id, frame_dlc, data_byte0, data_byte1,
                    input ready);
    modport sink   (input valid, action, frame_id, frame_dlc, data_byte0, data_byte1,
                    output ready);
endinterface

interface cstm_out_if import cstm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_value  measured_value;
    logic    engine_timed_out;
    logic    temperature_timed_out;
    logic    heartbeat_timed_out;

    modport source (output valid, status, measured_value, engine_timed_out,
                    temperature_timed_out, heartbeat_timed_out, input ready);
    modport sink   (input valid, status, measured_value, engine_timed_out,
                    temperature_timed_out, heartbeat_timed_out, output ready);
endinterface

interface cstm_cfg_if import cstm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_reg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/cstm_check.sv]
// Frame classifier: identifier match with priority and payload checks.
`timescale 1ns / 1ps

module cstm_check import cstm_pkg::*; (
    input  t_id    i_frame_id,
    input  t_dlc   i_frame_dlc,
    input  t_byte  i_data_byte0,
    input  t_byte  i_data_byte1,
    input  t_id    i_cfg_id [NUM_SIG],
    output t_check o_chk
);

    logic   w_is_engine;
    logic   w_is_temp;
    logic   w_is_heartbeat;
    t_value w_rpm;

    // Engine speed wins over temperature, temperature over heartbeat.
    assign w_is_engine    = (i_frame_id == i_cfg_id[SLOT_ENGINE]);
    assign w_is_temp      = !w_is_engine && (i_frame_id == i_cfg_id[SLOT_TEMP]);
    assign w_is_heartbeat = !w_is_engine && !w_is_temp &&
                            (i_frame_id == i_cfg_id[SLOT_HEARTBEAT]);

    // Engine speed is carried little-endian in the first two bytes.
    assign w_rpm = {i_data_byte1, i_data_byte0};

    // Status and decoded value for each kind of frame.
    always_comb begin
        o_chk.status = ST_UNMONITORED;
        o_chk.value  = '0;
        o_chk.hit    = {w_is_heartbeat, w_is_temp, w_is_engine};
        if (w_is_engine) begin
            if (i_frame_dlc != ENGINE_DLC) begin
                o_chk.status = ST_DLC;
            end else begin
                o_chk.value  = w_rpm;
                o_chk.status = (w_rpm < RPM_MIN || w_rpm > RPM_MAX) ? ST_RANGE : ST_OK;
            end
        end else if (w_is_temp) begin
            if (i_frame_dlc != TEMP_DLC) begin
                o_chk.status = ST_DLC;
            end else begin
                o_chk.value  = VAL_W'(i_data_byte0);
                o_chk.status = (i_data_byte0 > TEMP_MAX) ? ST_RANGE : ST_OK;
            end
        end else if (w_is_heartbeat) begin
            o_chk.status = (i_frame_dlc != HEARTBEAT_DLC || i_data_byte0 != HEARTBEAT_BYTE)
                           ? ST_HEARTBEAT : ST_OK;
        end
    end

endmodule

[design/can_signal_check_and_timeout_monitor.sv]
// Top level: configuration registers, seen marks, age counters and result register.
// A result is valid in the cycle after its item's transfer.
// Throughput: one item per cycle while results are taken; frame checks and the tick
// update of all three age counters are done in one pass into the result register.
// Input ready stays high while the result register is empty or being taken.
// Reset (synchronous, active low) clears seen marks, age counters and the result
// valid, and loads the default identifiers and timeouts.
`timescale 1ns / 1ps

module can_signal_check_and_timeout_monitor import cstm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cstm_in_if.sink     i_in,
    cstm_out_if.source  o_out,
    cstm_cfg_if.sink    i_cfg
);

    t_id                r_id    [NUM_SIG];
    t_timeout           r_limit [NUM_SIG];
    logic [NUM_SIG-1:0] r_seen;
    logic [NUM_SIG-1:0] n_seen;
    t_age               r_age   [NUM_SIG];
    t_age               n_age   [NUM_SIG];
    t_age               w_age_inc [NUM_SIG];
    logic [NUM_SIG-1:0] w_flags;
    logic               w_accept;
    t_check             w_chk;

    logic               r_out_valid;
    t_status            r_status;
    t_value             r_value;
    logic [NUM_SIG-1:0] r_flags;

    // Frame classification.
    cstm_check u_check (
        .i_frame_id   (i_in.frame_id),
        .i_frame_dlc  (i_in.frame_dlc),
        .i_data_byte0 (i_in.data_byte0),
        .i_data_byte1 (i_in.data_byte1),
        .i_cfg_id     (r_id),
        .o_chk        (w_chk)
    );

    // Input transfer whenever the result register is free or drains this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id[SLOT_ENGINE]       <= RST_ENGINE_ID;
            r_id[SLOT_TEMP]         <= RST_TEMP_ID;
            r_id[SLOT_HEARTBEAT]    <= RST_HEARTBEAT_ID;
            r_limit[SLOT_ENGINE]    <= RST_ENGINE_TO;
            r_limit[SLOT_TEMP]      <= RST_TEMP_TO;
            r_limit[SLOT_HEARTBEAT] <= RST_HEARTBEAT_TO;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ENGINE_ID:    r_id[SLOT_ENGINE]       <= i_cfg.data[ID_W-1:0];
                REG_TEMP_ID:      r_id[SLOT_TEMP]         <= i_cfg.data[ID_W-1:0];
                REG_HEARTBEAT_ID: r_id[SLOT_HEARTBEAT]    <= i_cfg.data[ID_W-1:0];
                REG_ENGINE_TO:    r_limit[SLOT_ENGINE]    <= i_cfg.data[TO_W-1:0];
                REG_TEMP_TO:      r_limit[SLOT_TEMP]      <= i_cfg.data[TO_W-1:0];
                REG_HEARTBEAT_TO: r_limit[SLOT_HEARTBEAT] <= i_cfg.data[TO_W-1:0];
                default: ;
            endcase
        end
    end

    // Next seen marks and ages: a tick ages every slot, a matching frame refreshes one.
    always_comb begin
        n_seen  = r_seen;
        w_flags = '0;
        for (int i = 0; i < NUM_SIG; i++) begin
            n_age[i]     = r_age[i];
            w_age_inc[i] = (r_age[i] == AGE_MAX) ? r_age[i] : r_age[i] + 1'b1;
            if (w_accept) begin
                if (i_in.action) begin
                    n_age[i] = w_age_inc[i];
                    if (r_seen[i] && (CMP_W'(w_age_inc[i]) > CMP_W'(r_limit[i]))) begin
                        w_flags[i] = 1'b1;
                        n_seen[i]  = 1'b0;
                    end
                end else if (w_chk.hit[i]) begin
                    n_seen[i] = 1'b1;
                    n_age[i]  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int i = 0; i < NUM_SIG; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_seen <= n_seen;
            for (int i = 0; i < NUM_SIG; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= i_in.action ? ST_TICK : w_chk.status;
            r_value  <= i_in.action ? '0 : w_chk.value;
            r_flags  <= w_flags;
        end
    end

    assign o_out.valid                 = r_out_valid;
    assign o_out.status                = r_status;
    assign o_out.measured_value        = r_value;
    assign o_out.engine_timed_out      = r_flags[SLOT_ENGINE];
    assign o_out.temperature_timed_out = r_flags[SLOT_TEMP];
    assign o_out.heartbeat_timed_out   = r_flags[SLOT_HEARTBEAT];

`ifndef NO_ASSERTIONS
    // A held result is never overwritten by a new transfer.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && r_out_valid) |-> o_out.ready)
        else $error("result register overwritten while stalled");

    // Timeout flags appear only on tick results.
    a_flags_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_TICK) |-> (r_flags == '0))
        else $error("timeout flag on a frame result");

    // An engine speed frame marks the slot seen and restarts its age.
    a_engine_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in.action && w_chk.hit[SLOT_ENGINE])
        |=> (r_seen[SLOT_ENGINE] && r_age[SLOT_ENGINE] == '0))
        else $error("engine frame did not refresh its slot");

    // A tick never sets the heartbeat seen mark when it was clear.
    a_tick_no_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.action && !r_seen[SLOT_HEARTBEAT]) |=> !r_seen[SLOT_HEARTBEAT])
        else $error("tick set a heartbeat seen mark");
`endif

endmodule
